### design/xks_pkg.sv
// ----------------------------------------------------------------------------
// xks_pkg
// Shared constants and types for the XOR keyed string scanner.
// ----------------------------------------------------------------------------
package xks_pkg;

    // Longest needle, terminator excluded.
    localparam int MAX_NEEDLE  = 16;
    // Width of the saturating byte counter inside one buffer.
    localparam int OFFSET_BITS = 32;

    // The window holds the needle bytes plus the terminator.
    localparam int WIN_DEPTH   = MAX_NEEDLE + 1;
    localparam int IDX_W       = $clog2(WIN_DEPTH);
    localparam int LEN_W       = 5;

    // Field widths of the streams and the register port.
    localparam int BYTE_W      = 8;
    localparam int HIT_OFF_W   = 32;
    localparam int ADDR_W      = 64;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = HIT_OFF_W + ADDR_W + BYTE_W;
    localparam int OUT_TUSER_W = 1;
    localparam int APB_DATA_W  = 64;
    localparam int APB_ADDR_W  = 6;
    localparam int REG_IDX_W   = 3;

    typedef logic [OFFSET_BITS-1:0] t_count;
    typedef logic [BYTE_W-1:0]      t_byte;

    // Register indexes, placed at byte address 8 * index.
    typedef enum logic [REG_IDX_W-1:0] {
        REG_NEEDLE_LEN  = 3'd0,
        REG_NEEDLE_LOW  = 3'd1,
        REG_NEEDLE_HIGH = 3'd2,
        REG_XOR_ENABLE  = 3'd3,
        REG_BASE_ADDR   = 3'd4
    } t_reg_idx;

endpackage

### design/xor_keyed_string_scanner_core.sv
// ----------------------------------------------------------------------------
// xor_keyed_string_scanner_core
// Streams a buffer byte by byte through a sliding window and reports where
// the window holds the needle plus a zero terminator, plain or XOR encoded.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Transfer when            Content
//  s stream  in         i_s_tvalid & o_s_tready  data_byte in tdata, last_byte
//                                                in tlast
//  m stream  out        o_m_tvalid & i_m_tready  hit_offset, hit_address,
//                                                xor_key in tdata, xor_encoded
//                                                in tuser
//  APB       in         psel & penable & pwrite  five registers, 8 bytes apart
//
//  One byte is taken every cycle while the input is not stalled. The byte
//  that completes a hit goes into the window stage; the compare and the
//  address add then feed the result register when the window stage
//  advances, and the hit is valid on the m stream from there.
//  While a result waits on the m side, one more byte is held in the window
//  stage; input stalls only when both stages are full. Reset clears the
//  window, the counter and the pipeline valid bits, and presets the registers.
//
module xor_keyed_string_scanner_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input stream. tdata: [7:0] data_byte. tlast: last_byte.
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [xks_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                            i_s_tlast,
    // Result stream. tdata: [31:0] hit_offset, [95:32] hit_address,
    // [103:96] xor_key. tuser: [0] xor_encoded.
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [xks_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    output logic [xks_pkg::OUT_TUSER_W-1:0] o_m_tuser,
    // Register port.
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic [xks_pkg::APB_ADDR_W-1:0]  i_paddr,
    input  logic [xks_pkg::APB_DATA_W-1:0]  i_pwdata,
    output logic [xks_pkg::APB_DATA_W-1:0]  o_prdata,
    output logic                            o_pready
);
    import xks_pkg::*;

    localparam t_count COUNT_MAX = {OFFSET_BITS{1'b1}};

    // Configuration registers.
    logic [LEN_W-1:0]  r_needle_len;
    logic [ADDR_W-1:0] r_needle_low;
    logic [ADDR_W-1:0] r_needle_high;
    logic              r_xor_enable;
    logic [ADDR_W-1:0] r_base_addr;

    // Window stage.
    t_byte             r_win [WIN_DEPTH];
    t_count            r_seen;
    t_count            r_start;
    logic              r_s1_valid;
    logic              r_s1_last;
    logic              r_s1_check;

    // Result stage.
    logic              r_o_valid;
    logic [HIT_OFF_W-1:0] r_o_offset;
    logic [ADDR_W-1:0] r_o_addr;
    logic              r_o_xor;
    t_byte             r_o_key;

    logic              s_xfer;
    logic              s1_adv;
    logic              wr_en;
    t_reg_idx          reg_idx;
    logic [LEN_W-1:0]  len_eff;
    t_count            seen_base;
    logic              counted;
    t_count            n_seen;
    t_count            need_cnt;
    logic              hit_plain;
    logic              hit_xor;
    t_byte             key;
    logic [2*ADDR_W-1:0] needle_all;
    logic [ADDR_W-1:0] start_ext;

    // Handshakes: the window stage moves on when the result register is free
    // or is being emptied in this cycle.
    assign s1_adv     = !r_o_valid || i_m_tready;
    assign o_s_tready = !r_s1_valid || s1_adv;
    assign s_xfer     = i_s_tvalid && o_s_tready;

    // Register port decode; unlisted indexes are ignored.
    assign o_pready = 1'b1;
    assign wr_en    = i_psel && i_penable && i_pwrite;
    assign reg_idx  = t_reg_idx'(i_paddr[APB_ADDR_W-1:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_needle_len  <= LEN_W'(1);
            r_needle_low  <= '0;
            r_needle_high <= '0;
            r_xor_enable  <= 1'b1;
            r_base_addr   <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_NEEDLE_LEN:  r_needle_len  <= i_pwdata[LEN_W-1:0];
                REG_NEEDLE_LOW:  r_needle_low  <= i_pwdata;
                REG_NEEDLE_HIGH: r_needle_high <= i_pwdata;
                REG_XOR_ENABLE:  r_xor_enable  <= i_pwdata[0];
                REG_BASE_ADDR:   r_base_addr   <= i_pwdata;
                default: ;
            endcase
        end
    end

    // Register readback.
    always_comb begin
        unique case (reg_idx)
            REG_NEEDLE_LEN:  o_prdata = APB_DATA_W'(r_needle_len);
            REG_NEEDLE_LOW:  o_prdata = r_needle_low;
            REG_NEEDLE_HIGH: o_prdata = r_needle_high;
            REG_XOR_ENABLE:  o_prdata = APB_DATA_W'(r_xor_enable);
            REG_BASE_ADDR:   o_prdata = r_base_addr;
            default:         o_prdata = '0;
        endcase
    end

    // Needle length clamped to the supported range.
    always_comb begin
        if (r_needle_len == '0) begin
            len_eff = LEN_W'(1);
        end else if (r_needle_len > LEN_W'(MAX_NEEDLE)) begin
            len_eff = LEN_W'(MAX_NEEDLE);
        end else begin
            len_eff = r_needle_len;
        end
    end

    // Byte counter for the incoming byte. A buffer end seen on the previous
    // byte restarts the count, and a saturated count marks the byte unchecked.
    assign seen_base = r_s1_last ? '0 : r_seen;
    assign counted   = (seen_base != COUNT_MAX);
    assign n_seen    = counted ? seen_base + t_count'(1) : seen_base;
    assign need_cnt  = t_count'(len_eff) + t_count'(1);

    // Window shift, cleared first after the end of a buffer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WIN_DEPTH; i++) begin
                r_win[i] <= '0;
            end
            r_seen     <= '0;
            r_s1_valid <= 1'b0;
            r_s1_last  <= 1'b0;
            r_s1_check <= 1'b0;
        end else begin
            if (s_xfer) begin
                r_win[0] <= i_s_tdata[BYTE_W-1:0];
                for (int i = 1; i < WIN_DEPTH; i++) begin
                    r_win[i] <= r_s1_last ? '0 : r_win[i-1];
                end
                r_seen     <= n_seen;
                r_s1_last  <= i_s_tlast;
                r_s1_check <= counted && (n_seen >= need_cnt);
                r_start    <= n_seen - need_cnt;
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // Parallel compare of the window against the needle, plain and keyed.
    assign needle_all = {r_needle_high, r_needle_low};
    assign key        = r_win[IDX_W'(len_eff)] ^ needle_all[BYTE_W-1:0];

    always_comb begin
        logic [IDX_W-1:0] idx;
        t_byte            w;
        t_byte            nb;
        hit_plain = (r_win[0] == '0);
        hit_xor   = r_xor_enable && (key != '0) && (r_win[0] == key);
        for (int k = 0; k < MAX_NEEDLE; k++) begin
            idx = IDX_W'(len_eff) - IDX_W'(k);
            w   = r_win[idx];
            nb  = needle_all[BYTE_W*k +: BYTE_W];
            if (LEN_W'(k) < len_eff) begin
                if (w != nb) begin
                    hit_plain = 1'b0;
                end
                if ((w ^ key) != nb) begin
                    hit_xor = 1'b0;
                end
            end
        end
    end

    assign start_ext = ADDR_W'(r_start);

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_adv) begin
            r_o_valid <= r_s1_valid && r_s1_check && (hit_plain || hit_xor);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_o_offset <= start_ext[HIT_OFF_W-1:0];
            r_o_addr   <= r_base_addr + start_ext;
            r_o_xor    <= !hit_plain;
            r_o_key    <= hit_plain ? '0 : key;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {r_o_key, r_o_addr, r_o_offset};
    assign o_m_tuser  = r_o_xor;

endmodule

### verif/tb_xor_keyed_string_scanner_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_xor_keyed_string_scanner_core
// Streams buffers of bytes into the scanner and checks every hit it reports
// against a cycle-free scanner model kept in the testbench. The run walks
// through several register settings: needle lengths at and past both ends,
// all-zero and all-one needles, XOR search on and off, and base addresses
// that wrap. Both stream sides idle at random, and the result side holds off
// once for a long stretch so that the core backs up into its input.
// ----------------------------------------------------------------------------
module tb_xor_keyed_string_scanner_core;
    import xks_pkg::*;

    localparam int unsigned RUN_LIMIT   = 400000;
    localparam int          PHASE_ITEMS = 225;
    localparam int          NUM_PHASES  = 8;
    // A hit leaves via the window stage and the result register; wait a bit longer.
    localparam int          SETTLE      = 8;

    typedef struct {
        t_byte data;
        logic  last;
        int    gap;
    } scan_item_t;

    typedef struct {
        logic [HIT_OFF_W-1:0] offset;
        logic [ADDR_W-1:0]    address;
        logic                 encoded;
        t_byte                key;
    } hit_t;

    // Clock and reset.
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Input stream.
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    // tdata: [7:0] data_byte.
    logic [IN_TDATA_W-1:0] i_s_tdata  = '0;
    // tlast: last_byte.
    logic                  i_s_tlast  = 1'b0;

    // Result stream.
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    // tdata: [31:0] hit_offset, [95:32] hit_address, [103:96] xor_key.
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    // tuser: [0] xor_encoded.
    logic [OUT_TUSER_W-1:0] o_m_tuser;

    // Register port.
    logic                  i_psel    = 1'b0;
    logic                  i_penable = 1'b0;
    logic                  i_pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] i_paddr   = '0;
    logic [APB_DATA_W-1:0] i_pwdata  = '0;
    logic [APB_DATA_W-1:0] o_prdata;
    logic                  o_pready;

    xor_keyed_string_scanner_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_psel     (i_psel),
        .i_penable  (i_penable),
        .i_pwrite   (i_pwrite),
        .i_paddr    (i_paddr),
        .i_pwdata   (i_pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready)
    );

    // Register copies used by the scanner model.
    logic [LEN_W-1:0]  cfg_len    = LEN_W'(1);
    logic [127:0]      cfg_needle = '0;
    logic              cfg_xor    = 1'b1;
    logic [ADDR_W-1:0] cfg_base   = '0;

    // Scanner model state.
    t_byte  win [WIN_DEPTH];
    t_count seen;

    scan_item_t  stream_bytes[$];
    hit_t        hits_due[$];
    int unsigned n_sent     = 0;
    int unsigned n_accepted = 0;
    int unsigned n_errors   = 0;
    int unsigned cycles     = 0;
    int unsigned hold_left  = 0;
    bit          hold_done  = 1'b0;
    bit          m_idle     = 1'b0;
    bit          s_idle;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Needle length as the core uses it: zero acts as one, the top is clamped.
    function automatic int unsigned eff_len();
        if (cfg_len == 0) return 1;
        if (cfg_len > MAX_NEEDLE) return MAX_NEEDLE;
        return cfg_len;
    endfunction

    function automatic t_byte needle_at(int unsigned j);
        return cfg_needle[8*j +: 8];
    endfunction

    // Shift one byte into the window and queue the hit it completes, if any.
    function automatic void scan_byte(t_byte b, logic last);
        int unsigned       n;
        logic              counted;
        logic              plain;
        logic              xr;
        t_byte             key;
        t_byte             w;
        logic [ADDR_W-1:0] start;
        hit_t              h;

        n = eff_len();
        counted = (seen != '1);
        for (int k = WIN_DEPTH - 1; k > 0; k--) win[k] = win[k-1];
        win[0] = b;
        if (counted) seen = seen + 1'b1;

        if (counted && seen >= n + 1) begin
            start = ADDR_W'(seen) - ADDR_W'(n + 1);
            key   = win[n] ^ needle_at(0);
            plain = (win[0] == 8'h00);
            xr    = cfg_xor && (key != 8'h00) && (win[0] == key);
            for (int unsigned k = 0; k < n; k++) begin
                w = win[n-k];
                if (w != needle_at(k)) plain = 1'b0;
                if ((w ^ key) != needle_at(k)) xr = 1'b0;
            end
            if (plain || xr) begin
                h.offset  = start[HIT_OFF_W-1:0];
                h.address = cfg_base + start;
                h.encoded = !plain;
                h.key     = plain ? 8'h00 : key;
                hits_due.insert(hits_due.size(), h);
            end
        end

        // A buffer ends here: the next byte starts a fresh window.
        if (last) begin
            seen = '0;
            foreach (win[k]) win[k] = 8'h00;
        end
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            n_errors++;
        end
    endfunction

    // Input driver: offers queued bytes, waiting each item's gap after a transfer.
    always @(posedge i_clk) begin
        static bit         holding  = 1'b0;
        static int         gap_left = 0;
        static scan_item_t it;

        if (!i_rst_n) begin
            holding  = 1'b0;
            gap_left = 0;
            i_s_tdata <= '0;
            i_s_tlast <= 1'b0;
        end else begin
            if (holding && o_s_tready) begin
                scan_byte(i_s_tdata, i_s_tlast);
                n_accepted <= n_accepted + 1;
                holding = 1'b0;
            end
            if (!holding) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (stream_bytes.size() != 0) begin
                    it = stream_bytes.pop_front();
                    i_s_tdata <= it.data;
                    i_s_tlast <= it.last;
                    gap_left = it.gap;
                    holding  = 1'b1;
                end
            end
        end
        i_s_tvalid <= holding;
    end

    // One long hold-off on the result side once traffic is well under way,
    // started while plenty of bytes are still waiting to be offered.
    always @(posedge i_clk) begin
        if (!hold_done && n_accepted >= 700 && stream_bytes.size() >= 40) begin
            hold_left <= 400;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Result monitor: checks each transfer against the oldest expected hit.
    always @(posedge i_clk) begin
        static int   m_wait = 0;
        static hit_t want;

        if (!i_rst_n) begin
            m_wait = 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (hits_due.size() == 0) begin
                    $display("%0t: unexpected hit, expected none, actual tdata %h tuser %h",
                             $time, o_m_tdata, o_m_tuser);
                    n_errors++;
                end else begin
                    want = hits_due.pop_front();
                    check_field("hit_offset", 64'(want.offset), 64'(o_m_tdata[31:0]));
                    check_field("hit_address", want.address, o_m_tdata[95:32]);
                    check_field("xor_key", 64'(want.key), 64'(o_m_tdata[103:96]));
                    check_field("xor_encoded", 64'(want.encoded), 64'(o_m_tuser[0]));
                end
                m_wait = m_idle ? int'($urandom_range(0, 12)) : 0;
            end else if (m_wait > 0) begin
                m_wait--;
            end
        end
        i_m_tready <= i_rst_n && (m_wait == 0) && (hold_left == 0);
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= RUN_LIMIT) begin
            $display("xor_keyed_string_scanner_core: mismatch");
            $finish;
        end
    end

    // Register write: setup cycle, then access cycle until pready.
    task automatic reg_write(t_reg_idx idx, logic [APB_DATA_W-1:0] value);
        @(posedge i_clk);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= {idx, 3'b000};
        i_pwdata  <= value;
        @(posedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        case (idx)
            REG_NEEDLE_LEN:  cfg_len = value[LEN_W-1:0];
            REG_NEEDLE_LOW:  cfg_needle[63:0] = value;
            REG_NEEDLE_HIGH: cfg_needle[127:64] = value;
            REG_XOR_ENABLE:  cfg_xor = value[0];
            REG_BASE_ADDR:   cfg_base = value;
            default: ;
        endcase
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
    endtask

    task automatic set_all(logic [LEN_W-1:0] len, logic [63:0] low, logic [63:0] high,
                           logic xr, logic [ADDR_W-1:0] base);
        reg_write(REG_NEEDLE_LEN, APB_DATA_W'(len));
        reg_write(REG_NEEDLE_LOW, low);
        reg_write(REG_NEEDLE_HIGH, high);
        reg_write(REG_XOR_ENABLE, APB_DATA_W'(xr));
        reg_write(REG_BASE_ADDR, base);
    endtask

    // Wait until every byte is in and every hit is out, then let the pipe settle.
    task automatic drain();
        while (stream_bytes.size() != 0 || n_accepted != n_sent || hits_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic void add_item(ref scan_item_t frame[$], input t_byte data);
        scan_item_t it;
        it.data = data;
        it.last = 1'b0;
        it.gap  = s_idle ? int'($urandom_range(0, 12)) : 0;
        frame.insert(frame.size(), it);
    endfunction

    // Append the needle XORed with key and its terminator; optionally spoil one byte.
    function automatic void add_needle(ref scan_item_t frame[$], input t_byte key,
                                       input bit spoil);
        int unsigned n;
        int unsigned bad;
        t_byte       b;

        n   = eff_len();
        bad = $urandom_range(0, n);
        for (int unsigned j = 0; j <= n; j++) begin
            b = (j < n) ? (needle_at(j) ^ key) : key;
            if (spoil && j == bad) b = b ^ t_byte'($urandom_range(1, 255));
            add_item(frame, b);
        end
    endfunction

    // Move a finished buffer into the driver queue, tagging its final byte if close is set.
    function automatic void send_frame(ref scan_item_t frame[$], input bit close);
        if (frame.size() == 0) return;
        if (close) frame[frame.size()-1].last = 1'b1;
        foreach (frame[k]) stream_bytes.insert(stream_bytes.size(), frame[k]);
        n_sent += frame.size();
        frame.delete();
    endfunction

    // Stimulus.
    initial begin
        scan_item_t  frame[$];
        int unsigned phase_start;
        int unsigned r;
        logic [LEN_W-1:0]  len;
        logic [63:0]       low;
        logic [63:0]       high;
        logic [ADDR_W-1:0] base;

        seen = '0;
        foreach (win[k]) win[k] = 8'h00;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: needle "abc", base just below the wrap point.
        s_idle = 1'b0;
        set_all(LEN_W'(3), 64'h0000_0000_0063_6261, '1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFE);
        add_needle(frame, 8'h00, 1'b0);
        add_needle(frame, 8'hFF, 1'b0);
        add_needle(frame, 8'h01, 1'b0);
        send_frame(frame, 1'b0);
        // A match cut by the end of a buffer must not hit.
        add_item(frame, 8'h61);
        add_item(frame, 8'h62);
        add_item(frame, 8'h63);
        send_frame(frame, 1'b1);
        add_item(frame, 8'h00);
        send_frame(frame, 1'b1);
        // Hit whose terminator is the last byte of a buffer.
        add_needle(frame, 8'h00, 1'b0);
        send_frame(frame, 1'b1);
        drain();

        // Random part, one register setting per phase.
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: len = '0;
                1: len = '1;
                2: len = LEN_W'(MAX_NEEDLE);
                3: len = LEN_W'(1);
                default: len = LEN_W'($urandom_range(0, 31));
            endcase
            low  = {$urandom, $urandom};
            high = {$urandom, $urandom};
            if (p == 0) begin
                low  = '0;
                high = '0;
            end else if (p == 1) begin
                low  = '1;
                high = '1;
            end
            case (p)
                2: base = '1;
                3: base = '0;
                default: base = {$urandom, $urandom};
            endcase
            set_all(len, low, high, p % 2 == 0, base);

            s_idle  = (p % 4 == 0) || (p % 4 == 2);
            m_idle <= (p % 4 == 0) || (p % 4 == 3);

            // Buffers of noise and needle copies: mostly clean, some spoiled.
            phase_start = n_sent;
            while (n_sent - phase_start < PHASE_ITEMS) begin
                repeat ($urandom_range(1, 4)) begin
                    repeat ($urandom_range(0, 5)) add_item(frame, t_byte'($urandom_range(0, 255)));
                    r = $urandom_range(0, 9);
                    if (r < 4)      add_needle(frame, 8'h00, 1'b0);
                    else if (r < 7) add_needle(frame, t_byte'($urandom_range(1, 255)), 1'b0);
                    else if (r < 9) add_needle(frame, t_byte'($urandom_range(0, 255)), 1'b1);
                end
                // Some buffers stay open into the next frame or across the next register writes.
                send_frame(frame, $urandom_range(0, 7) != 0);
            end
            drain();
        end

        if (n_errors == 0) begin
            $display("xor_keyed_string_scanner_core: match");
        end else begin
            $display("xor_keyed_string_scanner_core: mismatch");
        end
        $finish;
    end

endmodule
